// ----- src/slid_pkg.sv -----
`default_nettype none
package slid_pkg;

  // Number of values the store can hold.
  localparam int CAPACITY = 16;
  // Width of the fill count, wide enough to hold CAPACITY itself.
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int VAL_W = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_OUT_W = 5;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef struct packed {
    logic                    mode;
    logic signed [VAL_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic signed [VAL_W-1:0] removed_value;
    logic                    is_empty;
    logic [COUNT_OUT_W-1:0]  entry_count;
  } result_t;

  // Update enables broadcast to every cell.
  typedef struct packed {
    logic insert_en;
    logic delete_en;
  } ctl_t;

  // What one cell shows its neighbors.
  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] value;
    logic                    ge;
  } link_t;

endpackage
`default_nettype wire

// ----- src/slid_cell.sv -----
`default_nettype none
module slid_cell (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic signed [slid_pkg::VAL_W-1:0] key,
  input  wire slid_pkg::ctl_t                   ctl,
  input  wire slid_pkg::link_t                  left,
  input  wire slid_pkg::link_t                  right,
  output slid_pkg::link_t                       self,
  output logic                                  eq
);
  import slid_pkg::*;

  logic                    valid;
  logic signed [VAL_W-1:0] value;
  logic                    ge;

  // Stored values form a sorted valid prefix, so ge is false up to the
  // insertion point and true from there on.
  assign ge = !valid || (value >= key);
  assign eq = valid && (value == key);

  assign self.valid = valid;
  assign self.value = value;
  assign self.ge    = ge;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.insert_en && ge) begin
      if (left.ge) begin
        valid <= left.valid;
      end else begin
        valid <= 1'b1;
      end
    end else if (ctl.delete_en && ge) begin
      valid <= right.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.insert_en && ge) begin
      if (left.ge) begin
        value <= left.value;
      end else begin
        value <= key;
      end
    end else if (ctl.delete_en && ge) begin
      value <= right.value;
    end
  end

endmodule
`default_nettype wire

// ----- src/sorted_list_insert_delete_unit.sv -----
`default_nettype none
// A request transferred at a clock edge is first registered in req; the cells and the result register
// then update from it, and the result is shown, with done high, for one cycle.
// Throughput: one request per cycle; busy is tied low and the unit never holds off a request.
// The receiver cannot stall; each result is shown once and is gone after that cycle.
// Reset (rst, synchronous, active high) empties the store and drops any request in flight.
module sorted_list_insert_delete_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire slid_pkg::request_t request,
  output logic                    busy,
  output logic                    done,
  output slid_pkg::result_t       result
);
  import slid_pkg::*;

  // The store is a row of CAPACITY cells. Cell 0 holds the smallest value and
  // the valid cells always form a prefix of the row. The request value is
  // broadcast to every cell, and each cell compares it against its own entry
  // in parallel. On an insert, every cell at or past the insertion point takes
  // its left neighbor's entry, and the cell at the insertion point takes the
  // new value. On a delete, every cell at or past the first equal entry takes
  // its right neighbor's entry, which closes the gap.

  // The accepted request is registered and held while the cells act on it.
  logic     req_valid;
  request_t req;

  // The row needs no wait between requests, so busy stays low.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req <= request;
    end
  end

  // Fill count, kept alongside the row so that full and empty need no scan.
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  link_t [CAPACITY-1:0] links;
  logic  [CAPACITY-1:0] eq_vec;
  logic                 found;
  logic                 full;
  ctl_t                 ctl;

  assign found = |eq_vec;
  assign full  = (count == CNT_W'(CAPACITY));

  assign ctl.insert_en = req_valid && (req.mode == MODE_INSERT) && !full;
  assign ctl.delete_en = req_valid && (req.mode == MODE_DELETE) && found;

  link_t left_edge;
  link_t right_edge;

  // Nothing sits left of cell 0, so it never copies from the left. Past the
  // last cell the row reads as empty, which is shifted in on a delete.
  assign left_edge.valid  = 1'b0;
  assign left_edge.value  = '0;
  assign left_edge.ge     = 1'b0;
  assign right_edge.valid = 1'b0;
  assign right_edge.value = '0;
  assign right_edge.ge    = 1'b1;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    link_t left_in;
    link_t right_in;

    if (i == 0) begin : g_first
      assign left_in = left_edge;
    end else begin : g_mid_left
      assign left_in = links[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_in = right_edge;
    end else begin : g_mid_right
      assign right_in = links[i+1];
    end

    slid_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .key   (req.value),
      .ctl   (ctl),
      .left  (left_in),
      .right (right_in),
      .self  (links[i]),
      .eq    (eq_vec[i])
    );
  end

  always_comb begin
    count_next = count;
    if (ctl.insert_en) begin
      count_next = count + CNT_W'(1);
    end else if (ctl.delete_en) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Result register: filled at the same edge at which the cells update.
  result_t result_next;

  always_comb begin
    result_next.status        = ST_DONE;
    result_next.removed_value = '0;
    if (req.mode == MODE_INSERT) begin
      if (full) begin
        result_next.status = ST_FULL;
      end
    end else begin
      if (found) begin
        result_next.removed_value = req.value;
      end else begin
        result_next.status = ST_NOT_FOUND;
      end
    end
    result_next.is_empty    = (count_next == '0);
    // The reported count keeps only its low bits when the store is larger.
    result_next.entry_count = COUNT_OUT_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire
